FILE: rtl/positional_linear_list_macros.svh
// Assertion macros shared by the positional linear list RTL.
`ifndef POSITIONAL_LINEAR_LIST_MACROS_SVH
`define POSITIONAL_LINEAR_LIST_MACROS_SVH
`ifndef SYNTHESIS
`define PLL_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define PLL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define PLL_ASSERT(lbl, clk, rst, prop, msg)
`define PLL_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

FILE: rtl/pll_pkg.sv
// Shared types and constants of the positional linear list.
`default_nettype none
package pll_pkg;
   localparam int DEPTH_DEFAULT      = 64;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int POS_W              = 7;
   localparam int VALUE_W            = 32;
   localparam int IDX_MAX_W          = 12;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_DELETE = 2'd1,
      OP_FIND   = 2'd2,
      OP_SEARCH = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_BOUNDS    = 2'd1,
      STAT_FULL      = 2'd2,
      STAT_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_EMIT
   } fsm_state_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_REMOVE,
      CELL_LOAD,
      CELL_SCAN
   } cell_op_type;

   typedef struct packed {
      cell_op_type            op;
      logic [IDX_MAX_W-1:0]   index;
   } cell_cmd_type;

   typedef struct packed {
      fsm_state_type          state;
      logic [IDX_MAX_W:0]     count;
   } ctrl_status_type;
endpackage
`default_nettype wire

FILE: rtl/pll_ifs.sv
// Request and response channel interfaces of the positional linear list.
`default_nettype none
interface pll_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           opcode;
   logic [pll_pkg::POS_W-1:0]            position;
   logic signed [pll_pkg::VALUE_W-1:0]   value;

   modport source (output valid, output opcode, output position, output value, input ready);
   modport sink (input valid, input opcode, input position, input value, output ready);
endinterface

interface pll_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [1:0]                           status;
   logic signed [pll_pkg::VALUE_W-1:0]   result_value;
   logic [pll_pkg::POS_W-1:0]            result_position;
   logic [pll_pkg::POS_W-1:0]            list_length;
   logic                                 list_empty;

   modport source (output valid, output status, output result_value, output result_position,
                   output list_length, output list_empty, input ready);
   modport sink (input valid, input status, input result_value, input result_position,
                 input list_length, input list_empty, output ready);
endinterface
`default_nettype wire

FILE: rtl/pll_cell.sv
// One list cell: holds one entry and one readout stage of the chain.
`default_nettype none
module pll_cell #(
   parameter int DATA_WIDTH = pll_pkg::DATA_WIDTH_DEFAULT,
   parameter int INDEX      = 0
) (
   input  wire logic                    clock,
   input  wire pll_pkg::cell_cmd_type   cmd,
   input  wire logic [DATA_WIDTH-1:0]   wr_data,
   input  wire logic [DATA_WIDTH-1:0]   left_entry,
   input  wire logic [DATA_WIDTH-1:0]   right_entry,
   input  wire logic [DATA_WIDTH-1:0]   right_link,
   output logic [DATA_WIDTH-1:0]        entry,
   output logic [DATA_WIDTH-1:0]        link
);
   localparam logic [pll_pkg::IDX_MAX_W-1:0] MY_INDEX = pll_pkg::IDX_MAX_W'(INDEX);

   logic [DATA_WIDTH-1:0] entry_ff, entry_in;
   logic [DATA_WIDTH-1:0] link_ff, link_in;

   always_comb begin
      entry_in = entry_ff;
      link_in  = link_ff;
      unique case (cmd.op)
         pll_pkg::CELL_INSERT: begin
            priority if (MY_INDEX > cmd.index) begin
               entry_in = left_entry;
            end else if (MY_INDEX == cmd.index) begin
               entry_in = wr_data;
            end
         end
         pll_pkg::CELL_REMOVE: begin
            if (MY_INDEX >= cmd.index) begin
               entry_in = right_entry;
            end
         end
         pll_pkg::CELL_LOAD: begin
            link_in = entry_ff;
         end
         pll_pkg::CELL_SCAN: begin
            link_in = right_link;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      link_ff  <= link_in;
   end

   assign entry = entry_ff;
   assign link  = link_ff;
endmodule
`default_nettype wire

FILE: rtl/pll_ctrl.sv
// Request sequencer, length counter and response register of the list.
`default_nettype none
module pll_ctrl #(
   parameter int DEPTH      = pll_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pll_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   pll_req_if.sink                       req_chan,
   pll_rsp_if.source                     rsp_chan,
   output pll_pkg::cell_cmd_type         cell_cmd,
   output logic [DATA_WIDTH-1:0]         cell_data,
   input  wire logic [DATA_WIDTH-1:0]    head_link,
   output pll_pkg::ctrl_status_type      ctrl_stat
);
   localparam int IDX_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int POS_W = pll_pkg::POS_W;
   localparam int VAL_W = pll_pkg::VALUE_W;
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

   pll_pkg::fsm_state_type state_ff, state_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic [IDX_W-1:0]       step_ff, step_in;
   logic [IDX_W-1:0]       target_ff, target_in;
   pll_pkg::op_type        op_ff, op_in;
   logic [DATA_WIDTH-1:0]  key_ff, key_in;
   pll_pkg::status_type    res_status_ff, res_status_in;
   logic [VAL_W-1:0]       res_value_ff, res_value_in;
   logic [POS_W-1:0]       res_pos_ff, res_pos_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   pll_pkg::status_type    rsp_status_ff, rsp_status_in;
   logic [VAL_W-1:0]       rsp_value_ff, rsp_value_in;
   logic [POS_W-1:0]       rsp_pos_ff, rsp_pos_in;
   logic [POS_W-1:0]       rsp_length_ff, rsp_length_in;
   logic                   rsp_empty_ff, rsp_empty_in;

   logic                   req_fire;
   pll_pkg::op_type        req_op;
   logic [63:0]            req_wide;
   logic [DATA_WIDTH-1:0]  req_key;
   logic [CMP_W-1:0]       req_pos_ext;
   logic [CMP_W-1:0]       count_ext;
   logic                   pos_zero;
   logic                   pos_past;
   logic [63:0]            head_wide;
   logic [VAL_W-1:0]       head_out;
   logic [CNT_W-1:0]       step_next_cnt;
   logic                   step_last;
   logic                   step_hit;
   logic                   key_hit;
   logic                   rsp_free;

   assign req_fire      = req_chan.valid && req_chan.ready;
   assign req_op        = pll_pkg::op_type'(req_chan.opcode);
   assign req_wide      = 64'(req_chan.value);
   assign req_key       = req_wide[DATA_WIDTH-1:0];
   assign req_pos_ext   = CMP_W'(req_chan.position);
   assign count_ext     = CMP_W'(count_ff);
   assign pos_zero      = (req_chan.position == '0);
   assign pos_past      = (req_pos_ext > count_ext);
   assign head_wide     = 64'($signed(head_link));
   assign head_out      = head_wide[VAL_W-1:0];
   assign step_next_cnt = CNT_W'(step_ff) + CNT_W'(1);
   assign step_last     = (step_next_cnt == count_ff);
   assign step_hit      = (step_ff == target_ff);
   assign key_hit       = (head_link == key_ff);
   assign rsp_free      = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         pll_pkg::FSM_IDLE: begin
            if (req_fire) begin
               unique case (req_op)
                  pll_pkg::OP_INSERT: state_in = pll_pkg::FSM_EMIT;
                  pll_pkg::OP_DELETE,
                  pll_pkg::OP_FIND: begin
                     state_in = (pos_zero || pos_past) ? pll_pkg::FSM_EMIT : pll_pkg::FSM_SCAN;
                  end
                  pll_pkg::OP_SEARCH: begin
                     state_in = (count_ff == '0) ? pll_pkg::FSM_EMIT : pll_pkg::FSM_SCAN;
                  end
                  default: state_in = pll_pkg::FSM_EMIT;
               endcase
            end
         end
         pll_pkg::FSM_SCAN: begin
            if (op_ff == pll_pkg::OP_SEARCH) begin
               if (key_hit || step_last) begin
                  state_in = pll_pkg::FSM_EMIT;
               end
            end else if (step_hit) begin
               state_in = pll_pkg::FSM_EMIT;
            end
         end
         pll_pkg::FSM_EMIT: begin
            if (rsp_free) begin
               state_in = pll_pkg::FSM_IDLE;
            end
         end
         default: state_in = pll_pkg::FSM_IDLE;
      endcase
   end

   always_comb begin
      req_chan.ready = (state_ff == pll_pkg::FSM_IDLE);
      cell_cmd       = '{op: pll_pkg::CELL_HOLD, index: '0};
      cell_data      = req_key;
      count_in       = count_ff;
      step_in        = step_ff;
      target_in      = target_ff;
      op_in          = op_ff;
      key_in         = key_ff;
      res_status_in  = res_status_ff;
      res_value_in   = res_value_ff;
      res_pos_in     = res_pos_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_value_in   = rsp_value_ff;
      rsp_pos_in     = rsp_pos_ff;
      rsp_length_in  = rsp_length_ff;
      rsp_empty_in   = rsp_empty_ff;
      unique case (state_ff)
         pll_pkg::FSM_IDLE: begin
            if (req_fire) begin
               op_in         = req_op;
               key_in        = req_key;
               target_in     = IDX_W'(req_pos_ext - CMP_W'(1));
               step_in       = '0;
               res_value_in  = '0;
               res_pos_in    = '0;
               res_status_in = pll_pkg::STAT_OK;
               unique case (req_op)
                  pll_pkg::OP_INSERT: begin
                     priority if (pos_past) begin
                        res_status_in = pll_pkg::STAT_BOUNDS;
                     end else if (count_ff == FULL_COUNT) begin
                        res_status_in = pll_pkg::STAT_FULL;
                     end else begin
                        cell_cmd = '{op: pll_pkg::CELL_INSERT,
                                     index: pll_pkg::IDX_MAX_W'(req_chan.position)};
                        count_in = count_ff + CNT_W'(1);
                     end
                  end
                  pll_pkg::OP_DELETE,
                  pll_pkg::OP_FIND: begin
                     if (pos_zero || pos_past) begin
                        res_status_in = pll_pkg::STAT_BOUNDS;
                     end else begin
                        cell_cmd.op = pll_pkg::CELL_LOAD;
                     end
                  end
                  pll_pkg::OP_SEARCH: begin
                     if (count_ff == '0) begin
                        res_status_in = pll_pkg::STAT_NOT_FOUND;
                     end else begin
                        cell_cmd.op = pll_pkg::CELL_LOAD;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         pll_pkg::FSM_SCAN: begin
            if (op_ff == pll_pkg::OP_SEARCH) begin
               priority if (key_hit) begin
                  res_value_in = head_out;
                  res_pos_in   = POS_W'(step_next_cnt);
               end else if (step_last) begin
                  res_status_in = pll_pkg::STAT_NOT_FOUND;
               end else begin
                  cell_cmd.op = pll_pkg::CELL_SCAN;
                  step_in     = step_ff + IDX_W'(1);
               end
            end else if (step_hit) begin
               res_value_in = head_out;
               if (op_ff == pll_pkg::OP_DELETE) begin
                  cell_cmd = '{op: pll_pkg::CELL_REMOVE,
                               index: pll_pkg::IDX_MAX_W'(target_ff)};
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               cell_cmd.op = pll_pkg::CELL_SCAN;
               step_in     = step_ff + IDX_W'(1);
            end
         end
         pll_pkg::FSM_EMIT: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_value_in  = res_value_ff;
               rsp_pos_in    = res_pos_ff;
               rsp_length_in = POS_W'(count_ff);
               rsp_empty_in  = (count_ff == '0);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pll_pkg::FSM_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      step_ff       <= step_in;
      target_ff     <= target_in;
      op_ff         <= op_in;
      key_ff        <= key_in;
      res_status_ff <= res_status_in;
      res_value_ff  <= res_value_in;
      res_pos_ff    <= res_pos_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_pos_ff    <= rsp_pos_in;
      rsp_length_ff <= rsp_length_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.result_value    = rsp_value_ff;
   assign rsp_chan.result_position = rsp_pos_ff;
   assign rsp_chan.list_length     = rsp_length_ff;
   assign rsp_chan.list_empty      = rsp_empty_ff;

   assign ctrl_stat.state = state_ff;
   assign ctrl_stat.count = (pll_pkg::IDX_MAX_W + 1)'(count_ff);
endmodule
`default_nettype wire

FILE: rtl/positional_linear_list.sv
// Top level of the positional linear list: sequencer plus a chain of entry cells.
//
// The list keeps up to DEPTH values in a row of cells, entry k in cell k. An
// insert or a failed request passes through the emit state before the next
// request can be taken: the cells shift their entries when the request is
// accepted, and the response register is loaded in the emit state once it is
// free. Reads go through a readout chain that copies every entry into a shift
// stage and moves it one cell toward the head per cycle. A find or delete at
// position p stops the scan at that position, a search at the matching position
// or, on a miss, at the list length. A new request is accepted while the
// previous response still waits to be taken.
`default_nettype none
`include "positional_linear_list_macros.svh"
module positional_linear_list #(
   parameter int DEPTH      = pll_pkg::DEPTH_DEFAULT,
   parameter int DATA_WIDTH = pll_pkg::DATA_WIDTH_DEFAULT
) (
   input  wire logic   clock,
   input  wire logic   reset,
   pll_req_if.sink     req_chan,
   pll_rsp_if.source   rsp_chan
);
   pll_pkg::cell_cmd_type    cell_cmd;
   pll_pkg::ctrl_status_type ctrl_stat;
   logic [DATA_WIDTH-1:0]    cell_data;
   logic [DATA_WIDTH-1:0]    entry_bus [DEPTH];
   logic [DATA_WIDTH-1:0]    link_bus  [DEPTH];

   pll_ctrl #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .cell_cmd  (cell_cmd),
      .cell_data (cell_data),
      .head_link (link_bus[0]),
      .ctrl_stat (ctrl_stat)
   );

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_entry;
      logic [DATA_WIDTH-1:0] right_entry;
      logic [DATA_WIDTH-1:0] right_link;

      if (g == 0) begin : g_head
         assign left_entry = '0;
      end else begin : g_mid_left
         assign left_entry = entry_bus[g-1];
      end

      if (g == DEPTH - 1) begin : g_tail
         assign right_entry = entry_bus[g];
         assign right_link  = '0;
      end else begin : g_mid_right
         assign right_entry = entry_bus[g+1];
         assign right_link  = link_bus[g+1];
      end

      pll_cell #(
         .DATA_WIDTH (DATA_WIDTH),
         .INDEX      (g)
      ) u_cell (
         .clock       (clock),
         .cmd         (cell_cmd),
         .wr_data     (cell_data),
         .left_entry  (left_entry),
         .right_entry (right_entry),
         .right_link  (right_link),
         .entry       (entry_bus[g]),
         .link        (link_bus[g])
      );
   end

   `PLL_ASSERT(a_count_bound, clock, reset, ctrl_stat.count <= DEPTH, "List length exceeds depth.")
   `PLL_ASSERT_NEXT(a_count_step, clock, reset, 1'b1, (ctrl_stat.count == $past(ctrl_stat.count)) || (ctrl_stat.count == $past(ctrl_stat.count) + 1'b1) || (ctrl_stat.count == $past(ctrl_stat.count) - 1'b1), "List length moved by more than one.")
   `PLL_ASSERT(a_insert_room, clock, reset, (cell_cmd.op == pll_pkg::CELL_INSERT) |-> (ctrl_stat.count < DEPTH), "Insert issued to a full list.")
   `PLL_ASSERT(a_rsp_source, clock, reset, $rose(rsp_chan.valid) |-> ($past(ctrl_stat.state) == pll_pkg::FSM_EMIT), "Response raised outside the emit state.")
endmodule
`default_nettype wire
